### hdl/sti_pkg.sv
// Package for the sorted table: sizes, operation and status codes, and the
// control struct broadcast from the top level to every cell of the chain.
// No dependencies.
`timescale 1ns / 1ps

package sti_pkg;

   // Table size and key width.
   localparam int CAPACITY  = 16;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int COUNT_W   = $clog2(CAPACITY + 1);

   // Widths of the stream fields.
   localparam int OP_W     = 2;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = ((KEY_WIDTH + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_WIDTH + COUNT_W + 7) / 8) * 8;

   // Operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // Status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Control broadcast to every cell in the cycle a transaction is accepted.
   typedef struct packed {
      logic                 insert_en;
      logic                 remove_en;
      logic [KEY_WIDTH-1:0] new_key;
      logic [IDX_W-1:0]     pos;
      logic [COUNT_W-1:0]   count;
   } cell_ctl_type;

endpackage

### hdl/sti_cell.sv
// One cell of the sorted chain: holds a single key, compares it with the
// broadcast insert key and shifts with its neighbors. Depends on sti_pkg.
`timescale 1ns / 1ps

module sti_cell (
   input  logic                          clock,
   input  sti_pkg::cell_ctl_type         ctl,
   input  logic [sti_pkg::IDX_W-1:0]     cell_idx,
   input  logic                          left_less,
   input  logic [sti_pkg::KEY_WIDTH-1:0] left_key,
   input  logic [sti_pkg::KEY_WIDTH-1:0] right_key,
   output logic                          less,
   output logic [sti_pkg::KEY_WIDTH-1:0] key
);

   logic [sti_pkg::KEY_WIDTH-1:0] key_ff;
   logic [sti_pkg::KEY_WIDTH-1:0] key_in;
   logic                          occupied;

   // A stored key that is smaller than the new key stays where it is.
   assign occupied = {1'b0, cell_idx} < ctl.count;
   assign less     = occupied && (key_ff < ctl.new_key);
   assign key      = key_ff;

   // Insert: the first cell that is not less takes the new key, later cells
   // take their left neighbor. Remove: cells from the index on take the right.
   always_comb begin
      key_in = key_ff;
      priority if (ctl.insert_en) begin
         if (!less) begin
            key_in = left_less ? ctl.new_key : left_key;
         end
      end else if (ctl.remove_en && (cell_idx >= ctl.pos)) begin
         key_in = right_key;
      end else begin
         key_in = key_ff;
      end
   end

   // Key storage needs no reset; entries are written before they are read.
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

### hdl/sorted_table_insert_remove.sv
// Sorted table top level: request decode, chain of key cells, entry count
// and registered response. Depends on sti_pkg and sti_cell.
// The response is registered and appears in the cycle after the request is accepted.
// One transaction per cycle while the response is not stalled; every cell compares and shifts at once.
// Reset clears the entry count and the response valid; keys are not cleared.
`timescale 1ns / 1ps

module sorted_table_insert_remove (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Bits from lowest: key_value[31:0], position[35:32], zero fill.
   input  logic [sti_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Bits from lowest: op[1:0].
   input  logic [sti_pkg::OP_W-1:0]         req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Bits from lowest: read_key[31:0], entry_count[36:32], zero fill.
   output logic [sti_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Bits from lowest: status[1:0].
   output logic [sti_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int KW = sti_pkg::KEY_WIDTH;
   localparam int CW = sti_pkg::COUNT_W;

   logic                     accept;
   logic [KW-1:0]            new_key;
   logic [sti_pkg::POS_W-1:0] position;
   sti_pkg::op_type          op;
   logic                     full;
   logic                     in_range;
   sti_pkg::cell_ctl_type    ctl;

   logic [KW-1:0]            cell_key  [sti_pkg::CAPACITY];
   logic                     cell_less [sti_pkg::CAPACITY];

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [KW-1:0]            read_key_ff;
   logic [KW-1:0]            read_key_in;
   sti_pkg::status_type      status_ff;
   sti_pkg::status_type      status_in;
   logic [CW-1:0]            rsp_count_ff;

   // Unpack the request and check it against the current count.
   assign accept   = req_tvalid && req_tready;
   assign new_key  = req_tdata[KW-1:0];
   assign position = req_tdata[KW +: sti_pkg::POS_W];
   assign op       = sti_pkg::op_type'(req_tuser);
   assign full     = count_ff >= CW'(sti_pkg::CAPACITY);
   assign in_range = {1'b0, position} < count_ff;

   // Accept while the response register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;

   // Broadcast control to the cells.
   always_comb begin
      ctl.insert_en = accept && (op == sti_pkg::OP_INSERT) && !full;
      ctl.remove_en = accept && (op == sti_pkg::OP_REMOVE) && in_range;
      ctl.new_key   = new_key;
      ctl.pos       = position[sti_pkg::IDX_W-1:0];
      ctl.count     = count_ff;
   end

   // Chain of cells; cell zero sees an always-less left neighbor so it takes
   // the new key when its own key is not less.
   for (genvar i = 0; i < sti_pkg::CAPACITY; i++) begin : g_cell
      logic          left_less;
      logic [KW-1:0] left_key;
      logic [KW-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_less = 1'b1;
         assign left_key  = '0;
      end else begin : g_mid
         assign left_less = cell_less[i-1];
         assign left_key  = cell_key[i-1];
      end

      if (i == sti_pkg::CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      sti_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cell_idx  (sti_pkg::IDX_W'(i)),
         .left_less (left_less),
         .left_key  (left_key),
         .right_key (right_key),
         .less      (cell_less[i]),
         .key       (cell_key[i])
      );
   end

   // Next count, response fields and response valid.
   always_comb begin
      count_in    = count_ff;
      read_key_in = '0;
      status_in   = sti_pkg::STATUS_OK;
      if (accept) begin
         unique case (op)
            sti_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = sti_pkg::STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            sti_pkg::OP_LOOKUP: begin
               if (!in_range) begin
                  status_in = sti_pkg::STATUS_RANGE;
               end else begin
                  read_key_in = cell_key[position[sti_pkg::IDX_W-1:0]];
               end
            end
            sti_pkg::OP_REMOVE: begin
               if (!in_range) begin
                  status_in = sti_pkg::STATUS_RANGE;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = sti_pkg::STATUS_OK;
            end
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded on each accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         read_key_ff  <= read_key_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(sti_pkg::RSP_DATA_W - KW - CW)'(0), rsp_count_ff, read_key_ff};
   assign rsp_tuser  = status_ff;

endmodule

### hdl/sti_checker.sv
// Port-level checks for the sorted table top level, attached by bind.
// Depends on sti_pkg and sorted_table_insert_remove.
`timescale 1ns / 1ps

module sti_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sti_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sti_pkg::STATUS_W-1:0]   rsp_tuser
);

   localparam int KW = sti_pkg::KEY_WIDTH;
   localparam int CW = sti_pkg::COUNT_W;

   logic [KW-1:0] read_key;
   logic [CW-1:0] entry_count;

   assign read_key    = rsp_tdata[KW-1:0];
   assign entry_count = rsp_tdata[KW +: CW];

   // The count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> entry_count <= CW'(sti_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   // A dropped insert is reported only when the table is full.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == sti_pkg::STATUS_FULL)
         |-> entry_count == CW'(sti_pkg::CAPACITY))
      else $error("full status with table not full");

   // Any error status carries a zero key.
   a_err_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != sti_pkg::STATUS_OK) |-> read_key == '0)
      else $error("error response with nonzero key");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
         |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

endmodule

bind sorted_table_insert_remove sti_checker u_sti_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb.sv
// Self-checking testbench for the sorted key table: directed rows, then random
// insert/lookup/remove traffic with random gaps and stalls on both streams.
// Depends on sti_pkg and sorted_table_insert_remove.
`timescale 1ns / 1ps

module tb;

   localparam logic [sti_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [sti_pkg::KEY_WIDTH-1:0] read_key;
      sti_pkg::status_type           status;
      logic [sti_pkg::COUNT_W-1:0]   count;
   } table_result_type;

   typedef struct {
      logic [sti_pkg::OP_W-1:0]      op;
      logic [sti_pkg::KEY_WIDTH-1:0] key;
      logic [sti_pkg::POS_W-1:0]     pos;
      int                            reps;
      bit                            typed;
      table_result_type              res;
   } stim_row_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [sti_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [sti_pkg::OP_W-1:0]       req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sti_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [sti_pkg::STATUS_W-1:0]   rsp_tuser;

   // Shadow of the table contents, updated as each request transaction is accepted.
   logic [sti_pkg::KEY_WIDTH-1:0] shadow_keys[sti_pkg::CAPACITY];
   int unsigned                   shadow_count = 0;
   table_result_type              pending_results[$];

   int  errors = 0;
   bit  no_idle = 1'b0;
   int  n_ops[4];
   int  n_full = 0;
   int  n_range = 0;
   int  n_at_capacity = 0;
   int  n_at_empty = 0;

   sorted_table_insert_remove u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one operation to the shadow table and returns the response it should give.
   function automatic table_result_type apply_table_op(
         input logic [sti_pkg::OP_W-1:0] op,
         input logic [sti_pkg::KEY_WIDTH-1:0] key,
         input logic [sti_pkg::POS_W-1:0] pos);
      table_result_type r;
      int unsigned      slot;
      int unsigned      j;
      r.read_key = '0;
      r.status   = sti_pkg::STATUS_OK;
      case (op)
         sti_pkg::OP_INSERT: begin
            if (shadow_count >= sti_pkg::CAPACITY) begin
               r.status = sti_pkg::STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < shadow_count && shadow_keys[slot] < key) slot++;
               for (j = shadow_count; j > slot; j--) shadow_keys[j] = shadow_keys[j-1];
               shadow_keys[slot] = key;
               shadow_count++;
            end
         end
         sti_pkg::OP_LOOKUP: begin
            if (pos >= shadow_count) r.status = sti_pkg::STATUS_RANGE;
            else r.read_key = shadow_keys[pos];
         end
         sti_pkg::OP_REMOVE: begin
            if (pos >= shadow_count) begin
               r.status = sti_pkg::STATUS_RANGE;
            end else begin
               for (j = pos; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
               shadow_count--;
            end
         end
         default: ;
      endcase
      r.count = sti_pkg::COUNT_W'(shadow_count);
      return r;
   endfunction

   // Mostly back-to-back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Keys lean toward extremes and a narrow band so that equal keys are common.
   function automatic logic [sti_pkg::KEY_WIDTH-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return sti_pkg::KEY_WIDTH'($urandom_range(0, 7));
         5:       return sti_pkg::KEY_WIDTH'(32'h8000_0000 + $urandom_range(0, 3));
         default: return sti_pkg::KEY_WIDTH'($urandom);
      endcase
   endfunction

   // Positions are mostly valid indexes, sometimes anything the field allows.
   function automatic logic [sti_pkg::POS_W-1:0] pick_pos();
      if (shadow_count == 0 || $urandom_range(0, 7) == 0) begin
         return sti_pkg::POS_W'($urandom_range(0, sti_pkg::CAPACITY - 1));
      end
      return sti_pkg::POS_W'($urandom_range(0, shadow_count - 1));
   endfunction

   // Drives one request transaction and records what it should produce once accepted.
   task automatic send_request(input logic [sti_pkg::OP_W-1:0] op,
                               input logic [sti_pkg::KEY_WIDTH-1:0] key,
                               input logic [sti_pkg::POS_W-1:0] pos, input bit typed,
                               input table_result_type typed_res);
      int               gap;
      table_result_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sti_pkg::REQ_DATA_W'({pos, key});
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = apply_table_op(op, key, pos);
      pending_results.push_back(typed ? typed_res : pred);
      n_ops[op]++;
      if (pred.status == sti_pkg::STATUS_FULL) n_full++;
      if (pred.status == sti_pkg::STATUS_RANGE) n_range++;
      if (shadow_count == sti_pkg::CAPACITY) n_at_capacity++;
      if (shadow_count == 0) n_at_empty++;
   endtask

   // Holds the request stream off until every outstanding response has arrived.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Response stream back-pressure: mostly ready, short stalls, an occasional long one.
   int stall_left = 0;
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (no_idle || r < 70) begin
         rsp_tready <= 1'b1;
      end else if (r < 96) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(10, 50);
      end
   end

   // Checks each response transaction against the oldest outstanding expectation.
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: key %h status %0d count %0d", $time,
                     rsp_tdata[sti_pkg::KEY_WIDTH-1:0], rsp_tuser,
                     rsp_tdata[sti_pkg::KEY_WIDTH +: sti_pkg::COUNT_W]);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[sti_pkg::KEY_WIDTH-1:0] !== want.read_key) begin
               $display("%0t: read_key mismatch: expected %h, actual %h", $time,
                        want.read_key, rsp_tdata[sti_pkg::KEY_WIDTH-1:0]);
               errors++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                        want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[sti_pkg::KEY_WIDTH +: sti_pkg::COUNT_W] !== want.count) begin
               $display("%0t: entry_count mismatch: expected %0d, actual %0d", $time,
                        want.count, rsp_tdata[sti_pkg::KEY_WIDTH +: sti_pkg::COUNT_W]);
               errors++;
            end
         end
      end
   end

   // Ends the run if neither stream moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("sorted_table_insert_remove regression: fail");
      $finish;
   end

   // Stimulus: directed rows first, then random phases.
   initial begin
      stim_row_type               rows[$];
      table_result_type           none;
      int                         random_sent;
      int                         phase_len;
      int                         mode;
      int                         r;
      logic [sti_pkg::OP_W-1:0]   op;

      none = '{read_key: '0, status: sti_pkg::STATUS_OK, count: '0};
      rows = '{
         // Empty table: index errors and the unused code.
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_RANGE, 5'd0}},
         '{sti_pkg::OP_REMOVE, 32'h0, 4'd15, 1, 1, '{32'h0, sti_pkg::STATUS_RANGE, 5'd0}},
         '{OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd0}},
         // Extreme keys and an equal pair.
         '{sti_pkg::OP_INSERT, 32'hFFFF_FFFF, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd1}},
         '{sti_pkg::OP_INSERT, 32'h0, 4'd15, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd2}},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd2}},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd1, 1, 1,
           '{32'hFFFF_FFFF, sti_pkg::STATUS_OK, 5'd2}},
         '{sti_pkg::OP_INSERT, 32'h8000_0000, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd3}},
         '{sti_pkg::OP_INSERT, 32'h8000_0000, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd4}},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd2, 1, 0, none},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd4, 1, 1, '{32'h0, sti_pkg::STATUS_RANGE, 5'd4}},
         '{sti_pkg::OP_REMOVE, 32'h0, 4'd1, 1, 0, none},
         // Fill to capacity with equal keys, then insert into the full table.
         '{sti_pkg::OP_INSERT, 32'h5A5A_5A5A, 4'd0, 13, 0, none},
         '{sti_pkg::OP_INSERT, 32'h1, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_FULL, 5'd16}},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd15, 1, 1,
           '{32'hFFFF_FFFF, sti_pkg::STATUS_OK, 5'd16}},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd16}},
         '{sti_pkg::OP_REMOVE, 32'h0, 4'd15, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd15}},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd15, 1, 1, '{32'h0, sti_pkg::STATUS_RANGE, 5'd15}},
         '{sti_pkg::OP_INSERT, 32'hFFFF_FFFE, 4'd0, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd16}},
         '{sti_pkg::OP_REMOVE, 32'h0, 4'd0, 1, 0, none},
         '{sti_pkg::OP_LOOKUP, 32'h0, 4'd14, 1, 0, none},
         '{OP_UNUSED, 32'hA5A5_A5A5, 4'd7, 1, 1, '{32'h0, sti_pkg::STATUS_OK, 5'd15}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         repeat (rows[i].reps)
            send_request(rows[i].op, rows[i].key, rows[i].pos, rows[i].typed, rows[i].res);
      end
      wait_for_drain();

      // Random phases: fill-heavy, drain-heavy, balanced and lookup-heavy mixes.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         mode      = $urandom_range(0, 3);
         phase_len = $urandom_range(30, 120);
         no_idle   = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            case (mode)
               0:       op = (r < 65) ? sti_pkg::OP_INSERT : (r < 85) ? sti_pkg::OP_LOOKUP :
                             (r < 98) ? sti_pkg::OP_REMOVE : OP_UNUSED;
               1:       op = (r < 15) ? sti_pkg::OP_INSERT : (r < 40) ? sti_pkg::OP_LOOKUP :
                             (r < 98) ? sti_pkg::OP_REMOVE : OP_UNUSED;
               2:       op = (r < 33) ? sti_pkg::OP_INSERT : (r < 66) ? sti_pkg::OP_LOOKUP :
                             (r < 98) ? sti_pkg::OP_REMOVE : OP_UNUSED;
               default: op = (r < 30) ? sti_pkg::OP_INSERT : (r < 70) ? sti_pkg::OP_LOOKUP :
                             (r < 98) ? sti_pkg::OP_REMOVE : OP_UNUSED;
            endcase
            send_request(op, pick_key(), pick_pos(), 1'b0, none);
            random_sent++;
         end
         if ($urandom_range(0, 3) == 0) wait_for_drain();
      end
      no_idle = 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d inserts, %0d lookups, %0d removes and %0d unused-code requests.",
               n_ops[sti_pkg::OP_INSERT], n_ops[sti_pkg::OP_LOOKUP],
               n_ops[sti_pkg::OP_REMOVE], n_ops[OP_UNUSED]);
      $display("Saw %0d full-table drops, %0d index errors; table full %0d times, empty %0d.",
               n_full, n_range, n_at_capacity, n_at_empty);
      if (errors == 0) begin
         $display("sorted_table_insert_remove regression: pass");
      end else begin
         $display("sorted_table_insert_remove regression: fail");
      end
      $finish;
   end

endmodule

### files.f
hdl/sti_pkg.sv
hdl/sti_cell.sv
hdl/sorted_table_insert_remove.sv
hdl/sti_checker.sv
tb/tb.sv
